>>> hdl/bba_pkg.sv
// ----------------------------------------------------------------------------
// bba_pkg
// Shared types and constants for the bitmap block allocator: the request and
// response payloads and the controller/datapath command and status bundles.
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MAX_BLOCKS   = 4096;
    localparam int WORD_BITS    = 32;
    localparam int BITMAP_WORDS = MAX_BLOCKS / WORD_BITS;
    localparam int WORD_AW      = $clog2(BITMAP_WORDS);
    localparam int BIT_AW       = $clog2(WORD_BITS);
    localparam int BLK_W        = 12;
    localparam int CNT_W        = 13;
    localparam int GROW_KNEE    = 1024;
    localparam int CAP_RESET    = 4;
    localparam int FREE_RESET   = 1;

    localparam logic [WORD_BITS-1:0] RESERVED_MASK = 32'h0000_0007;

    typedef enum logic {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } t_cmd;

    typedef enum logic {
        ST_OK   = 1'b0,
        ST_FULL = 1'b1
    } t_status;

    typedef struct packed {
        t_cmd             cmd;
        logic [BLK_W-1:0] block_index;
    } t_req;

    typedef struct packed {
        logic [BLK_W-1:0] granted_block;
        t_status          status;
        logic [CNT_W-1:0] free_blocks;
        logic [CNT_W-1:0] capacity_now;
    } t_rsp;

    // controller -> datapath
    typedef struct packed {
        logic latch;       // capture request, clear result fields
        logic grow;        // grow capacity if the free count is zero, read word 0
        logic scan_eval;   // evaluate current word, commit or step to next word
        logic free_rd;     // read the word holding the named block
        logic free_eval;   // clear the named bit if it is set and in range
        logic out_load;    // load the response register
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic scan_done;   // current word ends the scan (grant or full)
    } t_dp_sts;

endpackage

>>> hdl/bba_dp.sv
// ----------------------------------------------------------------------------
// bba_dp
// Datapath: bitmap memory with per-word valid bits, capacity and free count,
// one-word-per-cycle first-fit scan and the response register.
// ----------------------------------------------------------------------------
module bba_dp (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bba_pkg::t_req   i_req,
    input  bba_pkg::t_dp_cmd i_cmd,
    output bba_pkg::t_dp_sts o_sts,
    output bba_pkg::t_rsp   o_rsp
);
    import bba_pkg::*;

    function automatic logic [BIT_AW-1:0] lowest_zero(input logic [WORD_BITS-1:0] w);
        logic [BIT_AW-1:0] p;
        p = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!w[i]) begin
                p = BIT_AW'(i);
            end
        end
        return p;
    endfunction

    logic [WORD_BITS-1:0] mem [BITMAP_WORDS];
    logic [BITMAP_WORDS-1:0] r_vld;

    logic [BLK_W-1:0]     r_idx;
    logic [CNT_W-1:0]     r_cap;
    logic [CNT_W-1:0]     r_free;
    logic [WORD_AW-1:0]   r_word;
    logic [BLK_W-1:0]     r_granted;
    t_status              r_status;
    t_rsp                 r_rsp;
    logic [WORD_BITS-1:0] r_rd_data;
    logic                 r_rd_vld;
    logic                 r_rd_zero;

    logic [WORD_BITS-1:0] word_q;
    logic [BIT_AW-1:0]    pos;
    logic                 has_zero;
    logic [BLK_W-1:0]     blk;
    logic                 hit;
    logic                 more;
    logic [CNT_W-1:0]     next_base;
    logic [CNT_W:0]       grow_raw;
    logic [CNT_W-1:0]     grow_cap;
    logic [WORD_AW-1:0]   idx_word;
    logic [BIT_AW-1:0]    idx_bit;
    logic                 free_ok;
    logic                 rd_en;
    logic [WORD_AW-1:0]   rd_addr;
    logic                 wr_en;
    logic [WORD_AW-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;

    assign idx_word = r_idx[BLK_W-1 -: WORD_AW];
    assign idx_bit  = r_idx[BIT_AW-1:0];

    // never-written words read as their reset value
    assign word_q   = r_rd_vld ? r_rd_data : (r_rd_zero ? RESERVED_MASK : '0);
    assign pos      = lowest_zero(word_q);
    assign has_zero = ~&word_q;
    assign blk      = {r_word, pos};
    assign hit      = has_zero && ({1'b0, blk} < r_cap);
    assign next_base = CNT_W'({r_word, {BIT_AW{1'b0}}}) + CNT_W'(WORD_BITS);
    assign more     = !has_zero && (next_base < r_cap);

    assign o_sts.scan_done = hit || !more;

    // doubling below the knee, +25% above, clamped
    always_comb begin
        if (r_cap < CNT_W'(GROW_KNEE)) begin
            grow_raw = {r_cap, 1'b0};
        end else begin
            grow_raw = {1'b0, r_cap} + {3'b000, r_cap[CNT_W-1:2]};
        end
        if (grow_raw > (CNT_W+1)'(MAX_BLOCKS)) begin
            grow_cap = CNT_W'(MAX_BLOCKS);
        end else begin
            grow_cap = grow_raw[CNT_W-1:0];
        end
    end

    assign free_ok = ({1'b0, r_idx} < r_cap) && word_q[idx_bit];

    assign rd_en   = i_cmd.grow || i_cmd.free_rd || (i_cmd.scan_eval && more);
    assign rd_addr = i_cmd.grow ? '0 : (i_cmd.free_rd ? idx_word : r_word + 1'b1);

    assign wr_en   = (i_cmd.scan_eval && hit) || (i_cmd.free_eval && free_ok);
    assign wr_addr = i_cmd.scan_eval ? r_word : idx_word;
    assign wr_data = i_cmd.scan_eval ? (word_q | (WORD_BITS'(1) << pos))
                                     : (word_q & ~(WORD_BITS'(1) << idx_bit));

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_cap  <= CNT_W'(CAP_RESET);
            r_free <= CNT_W'(FREE_RESET);
        end else begin
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.grow && (r_free == '0) && (grow_cap > r_cap)) begin
                r_cap  <= grow_cap;
                r_free <= r_free + (grow_cap - r_cap);
            end else if (i_cmd.scan_eval && hit && (r_free != '0)) begin
                r_free <= r_free - 1'b1;
            end else if (i_cmd.free_eval && free_ok) begin
                r_free <= r_free + 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_vld  <= r_vld[rd_addr];
            r_rd_zero <= (rd_addr == '0);
        end
        if (i_cmd.latch) begin
            r_idx     <= i_req.block_index;
            r_granted <= '0;
            r_status  <= ST_OK;
        end
        if (i_cmd.grow) begin
            r_word <= '0;
        end else if (i_cmd.scan_eval) begin
            if (hit) begin
                r_granted <= blk;
            end else if (!more) begin
                r_status <= ST_FULL;
            end else begin
                r_word <= r_word + 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_rsp.granted_block <= r_granted;
            r_rsp.status        <= r_status;
            r_rsp.free_blocks   <= r_free;
            r_rsp.capacity_now  <= r_cap;
        end
    end

    assign o_rsp = r_rsp;

    a_cap_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cap >= CNT_W'(CAP_RESET)) && (r_cap <= CNT_W'(MAX_BLOCKS)))
        else $error("capacity out of range");

    a_cap_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cap >= $past(r_cap))
        else $error("capacity shrank");

    a_free_le_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= r_cap)
        else $error("free count exceeds capacity");

endmodule

>>> hdl/bba_ctrl.sv
// ----------------------------------------------------------------------------
// bba_ctrl
// Controller: sequences one request through grow and scan, or through free,
// then hands the result to the response register and tracks its valid flag.
// ----------------------------------------------------------------------------
module bba_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  bba_pkg::t_cmd    i_req_cmd,
    output logic             o_req_stall,
    output logic             o_rsp_valid,
    input  logic             i_rsp_stall,
    input  bba_pkg::t_dp_sts i_sts,
    output bba_pkg::t_dp_cmd o_cmd
);
    import bba_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GROW,
        S_SCAN,
        S_FREE_RD,
        S_FREE_WR,
        S_DONE
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept;
    logic   can_load;

    assign o_req_stall = (r_state != S_IDLE);
    assign accept      = i_req_valid && !o_req_stall;
    assign can_load    = !r_out_valid || !i_rsp_stall;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    o_cmd.latch = 1'b1;
                    n_state = (i_req_cmd == CMD_FREE) ? S_FREE_RD : S_GROW;
                end
            end
            S_GROW: begin
                o_cmd.grow = 1'b1;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_cmd.scan_eval = 1'b1;
                if (i_sts.scan_done) begin
                    n_state = S_DONE;
                end
            end
            S_FREE_RD: begin
                o_cmd.free_rd = 1'b1;
                n_state = S_FREE_WR;
            end
            S_FREE_WR: begin
                o_cmd.free_eval = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                if (can_load) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = (r_out_valid && i_rsp_stall) || o_cmd.out_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_req_stall)
        else $error("request taken but controller not busy");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) && can_load |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result not handed to response register");

    a_scan_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) && !i_sts.scan_done |=> (r_state == S_SCAN))
        else $error("scan left before a decision");

endmodule

>>> hdl/bitmap_block_allocator.sv
// Sequence: a free request passes FREE_RD, FREE_WR and DONE after accept; an
//   allocate passes GROW, SCAN over k words (1 to 128, one word per cycle), DONE.
// Throughput: one request at a time; the next is taken once the result sits
//   in the response register, but it then waits in DONE while that is stalled.
// Reset: synchronous, active low; capacity 4, free count 1, blocks 0-2 used.
//   Per-word valid bits replace a clearing pass, so requests are taken at once.
// ----------------------------------------------------------------------------
// bitmap_block_allocator
// First-fit block allocator over a used-block bitmap held in 32-bit words.
// ----------------------------------------------------------------------------
module bitmap_block_allocator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // request channel
    input  logic          i_req_valid,
    output logic          o_req_stall,
    input  bba_pkg::t_req i_req,
    // response channel
    output logic          o_rsp_valid,
    input  logic          i_rsp_stall,
    output bba_pkg::t_rsp o_rsp
);
    import bba_pkg::*;

    // Controller walks IDLE -> GROW -> SCAN... -> DONE for allocate, and
    // IDLE -> FREE_RD -> FREE_WR -> DONE for free. Datapath holds the bitmap
    // memory (registered read), capacity, free count and response register.
    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .i_req_cmd   (i_req.cmd),
        .o_req_stall (o_req_stall),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_stall (i_rsp_stall),
        .i_sts       (dp_sts),
        .o_cmd       (dp_cmd)
    );

    bba_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_cmd   (dp_cmd),
        .o_sts   (dp_sts),
        .o_rsp   (o_rsp)
    );

endmodule
